// ----- sv/rbc_pkg.sv -----
package rbc_pkg;

    // Field widths
    localparam int unsigned ATTEMPT_W = 8;
    localparam int unsigned INIT_W    = 20;
    localparam int unsigned GROWTH_W  = 16;
    localparam int unsigned DELAY_W   = 32;
    localparam int unsigned STATUS_W  = 10;
    localparam int unsigned HINT_W    = 16;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned BACKOFF_W = 48;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;

    // Verdict codes
    typedef enum logic [1:0] {
        VERDICT_DELIVER = 2'd0,
        VERDICT_RETRY   = 2'd1,
        VERDICT_FAIL    = 2'd2
    } t_verdict;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CAP   = 8'd3;

    // Register reset values
    localparam logic [ATTEMPT_W-1:0] RST_RETRY_LIMIT = 8'd3;
    localparam logic [INIT_W-1:0]    RST_INIT_DELAY  = 20'd500;
    localparam logic [GROWTH_W-1:0]  RST_GROWTH      = 16'd512;
    localparam logic [DELAY_W-1:0]   RST_DELAY_CAP   = 32'd30000;

    // Status codes worth another attempt
    localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 10'd408;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 10'd429;
    localparam logic [STATUS_W-1:0] ST_INTERNAL    = 10'd500;
    localparam logic [STATUS_W-1:0] ST_BAD_GATEWAY = 10'd502;
    localparam logic [STATUS_W-1:0] ST_UNAVAILABLE = 10'd503;
    localparam logic [STATUS_W-1:0] ST_GW_TIMEOUT  = 10'd504;

    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    typedef struct packed {
        logic [ATTEMPT_W-1:0] retry_limit;
        logic [INIT_W-1:0]    initial_delay_ms;
        logic [GROWTH_W-1:0]  growth_factor_q8;
        logic [DELAY_W-1:0]   delay_cap_ms;
    } t_cfg;

    typedef struct packed {
        logic                link_failed;
        logic [STATUS_W-1:0] status_code;
        logic                hint_present;
        logic [HINT_W-1:0]   hint_seconds;
    } t_item;

    typedef struct packed {
        logic [ATTEMPT_W-1:0] attempt_count;
        logic [BACKOFF_W-1:0] running_backoff;
    } t_state;

    typedef struct packed {
        t_verdict             verdict;
        logic [DELAY_W-1:0]   delay_ms;
        logic [ATTEMPT_W-1:0] attempt_index;
    } t_result;

endpackage

// ----- sv/rbc_decide.sv -----
module rbc_decide
    import rbc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_state  i_state,
    output t_result o_result,
    output t_state  o_state_next
);

    logic                  may_retry;
    logic                  retryable;
    t_verdict              verdict;
    logic [BACKOFF_W-1:0]  init_fixed;
    logic [BACKOFF_W-1:0]  base;
    logic [BACKOFF_W:0]    exp_sum;
    logic [DELAY_W:0]      exp_delay;
    logic [25:0]           hint_ms;
    logic [DELAY_W:0]      raw_delay;
    logic [DELAY_W-1:0]    clamped;
    logic [63:0]           prod_full;
    logic [64:0]           prod_rnd;
    logic [56:0]           prod_q16;
    logic [BACKOFF_W-1:0]  prod_sat;

    // Classify the outcome
    always_comb begin
        may_retry = i_state.attempt_count < i_cfg.retry_limit;
        retryable = i_item.status_code inside {ST_TIMEOUT, ST_TOO_MANY, ST_INTERNAL,
                                               ST_BAD_GATEWAY, ST_UNAVAILABLE,
                                               ST_GW_TIMEOUT};
        if (i_item.link_failed) begin
            verdict = may_retry ? VERDICT_RETRY : VERDICT_FAIL;
        end else if (retryable && may_retry) begin
            verdict = VERDICT_RETRY;
        end else begin
            verdict = VERDICT_DELIVER;
        end
    end

    // Work out the delay and the next running product
    always_comb begin
        init_fixed = {12'd0, i_cfg.initial_delay_ms, 16'd0};
        base       = (i_state.attempt_count == '0) ? init_fixed : i_state.running_backoff;

        // round the Q.16 base to whole milliseconds
        exp_sum   = {1'b0, base} + 49'h8000;
        exp_delay = exp_sum[BACKOFF_W:FRAC_W];

        hint_ms   = {10'd0, i_item.hint_seconds} * {16'd0, MS_PER_SEC};
        raw_delay = (!i_item.link_failed && i_item.hint_present)
                    ? {7'd0, hint_ms} : exp_delay;
        clamped   = (raw_delay > {1'b0, i_cfg.delay_cap_ms})
                    ? i_cfg.delay_cap_ms : raw_delay[DELAY_W-1:0];

        // grow by the Q8.8 factor, round half-up, saturate at all ones
        prod_full = {16'd0, base} * {48'd0, i_cfg.growth_factor_q8};
        prod_rnd  = {1'b0, prod_full} + 65'd128;
        prod_q16  = prod_rnd[64:8];
        prod_sat  = (|prod_q16[56:BACKOFF_W]) ? '1 : prod_q16[BACKOFF_W-1:0];
    end

    // Drive the result and the state update
    always_comb begin
        o_result.verdict       = verdict;
        o_result.attempt_index = i_state.attempt_count;
        if (verdict == VERDICT_RETRY) begin
            o_result.delay_ms            = clamped;
            o_state_next.attempt_count   = i_state.attempt_count + 8'd1;
            o_state_next.running_backoff = prod_sat;
        end else begin
            o_result.delay_ms            = '0;
            o_state_next.attempt_count   = '0;
            o_state_next.running_backoff = init_fixed;
        end
    end

endmodule

// ----- sv/retry_backoff_controller_unit.sv -----
// Retry backoff controller: takes one attempt outcome per beat and returns one verdict
// (deliver, retry after delay_ms, or fail) with the zero-based attempt index. Throughput
// is one outcome per clock, back to back, while the verdict side does not stall. An
// accepted beat sits in the input register, is worked out and is loaded into the result
// register, from which its verdict is offered; a stalled verdict side holds both
// registers. Between the two registers sit a 48x16 multiply for the running backoff
// product, a 16x10 multiply for the Retry-After hint and a few compares. Configuration
// writes are always ready and take effect from the next outcome; write them only while no
// outcome is in flight.
module retry_backoff_controller_unit
    import rbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // outcome channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_link_failed,
    input  logic [STATUS_W-1:0]  i_status_code,
    input  logic                 i_hint_present,
    input  logic [HINT_W-1:0]    i_hint_seconds,
    // verdict channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_verdict,
    output logic [DELAY_W-1:0]   o_delay_ms,
    output logic [ATTEMPT_W-1:0] o_attempt_index
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result r_result;
    t_result n_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    // Move a beat on when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    rbc_decide u_decide (
        .i_cfg        (r_cfg),
        .i_item       (r_item),
        .i_state      (r_state),
        .o_result     (n_result),
        .o_state_next (n_state)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit      <= RST_RETRY_LIMIT;
            r_cfg.initial_delay_ms <= RST_INIT_DELAY;
            r_cfg.growth_factor_q8 <= RST_GROWTH;
            r_cfg.delay_cap_ms     <= RST_DELAY_CAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RETRY_LIMIT: r_cfg.retry_limit      <= i_cfg_data[ATTEMPT_W-1:0];
                CFG_INIT_DELAY:  r_cfg.initial_delay_ms <= i_cfg_data[INIT_W-1:0];
                CFG_GROWTH:      r_cfg.growth_factor_q8 <= i_cfg_data[GROWTH_W-1:0];
                CFG_DELAY_CAP:   r_cfg.delay_cap_ms     <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid              <= 1'b0;
            r_out_valid             <= 1'b0;
            r_state.attempt_count   <= '0;
            r_state.running_backoff <= {12'd0, RST_INIT_DELAY, 16'd0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid             <= 1'b1;
                r_state.attempt_count   <= n_state.attempt_count;
                r_state.running_backoff <= n_state.running_backoff;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.link_failed  <= i_link_failed;
            r_item.status_code  <= i_status_code;
            r_item.hint_present <= i_hint_present;
            r_item.hint_seconds <= i_hint_seconds;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_result.verdict;
    assign o_delay_ms      = r_result.delay_ms;
    assign o_attempt_index = r_result.attempt_index;

endmodule

// ----- tb/tb_retry_backoff_controller_unit.sv -----
`timescale 1ns / 100ps

module tb_retry_backoff_controller_unit;
    import rbc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_ROWS    = 21;
    localparam int NUM_PHASES  = 7;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;

    // One directed outcome, with its verdict where it is obvious
    typedef struct packed {
        logic                 link_failed;
        logic [STATUS_W-1:0]  status_code;
        logic                 hint_present;
        logic [HINT_W-1:0]    hint_seconds;
        logic                 known;
        t_verdict             verdict;
        logic [DELAY_W-1:0]   delay_ms;
        logic [ATTEMPT_W-1:0] attempt_index;
    } t_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 i_link_failed   = 1'b0;
    logic [STATUS_W-1:0]  i_status_code   = '0;
    logic                 i_hint_present  = 1'b0;
    logic [HINT_W-1:0]    i_hint_seconds  = '0;
    logic                 i_out_ready     = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_verdict;
    logic [DELAY_W-1:0]   o_delay_ms;
    logic [ATTEMPT_W-1:0] o_attempt_index;

    // Shadow copy of the registers and the backoff state
    t_cfg                 shadow_cfg;
    logic [ATTEMPT_W-1:0] tries_seen;
    logic [BACKOFF_W-1:0] backoff_product;

    t_result verdicts_due[$];
    logic    steady_phase  = 1'b0;
    int      error_count   = 0;
    int      outcomes_sent = 0;
    int      retries_seen  = 0;
    int      delivers_seen = 0;
    int      fails_seen    = 0;
    int      cycle_count   = 0;

    // Directed outcomes under the reset settings: limit 3, 500 ms, growth 2.0, cap 30 s
    t_row directed_rows [0:NUM_ROWS-1] = '{
        '{1'b1, 10'd0,    1'b0, 16'd0,     1'b1, VERDICT_RETRY,   32'd500,   8'd0},
        '{1'b0, 10'd503,  1'b1, 16'd7,     1'b1, VERDICT_RETRY,   32'd7000,  8'd1},
        '{1'b1, 10'd1023, 1'b1, 16'd65535, 1'b1, VERDICT_RETRY,   32'd2000,  8'd2},
        '{1'b1, 10'd0,    1'b0, 16'd0,     1'b1, VERDICT_FAIL,    32'd0,     8'd3},
        '{1'b0, 10'd200,  1'b0, 16'd0,     1'b1, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd408,  1'b1, 16'd65535, 1'b1, VERDICT_RETRY,   32'd30000, 8'd0},
        '{1'b0, 10'd429,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd404,  1'b1, 16'd3,     1'b1, VERDICT_DELIVER, 32'd0,     8'd2},
        '{1'b0, 10'd1023, 1'b1, 16'd65535, 1'b1, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd0,    1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd500,  1'b1, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd502,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd504,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd503,  1'b1, 16'd1,     1'b1, VERDICT_DELIVER, 32'd0,     8'd3},
        '{1'b0, 10'd399,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd501,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b1, 10'd408,  1'b1, 16'd30,    1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd200,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd503,  1'b1, 16'd30,    1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd503,  1'b1, 16'd31,    1'b0, VERDICT_DELIVER, 32'd0,     8'd0},
        '{1'b0, 10'd200,  1'b0, 16'd0,     1'b0, VERDICT_DELIVER, 32'd0,     8'd0}
    };

    retry_backoff_controller_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_link_failed   (i_link_failed),
        .i_status_code   (i_status_code),
        .i_hint_present  (i_hint_present),
        .i_hint_seconds  (i_hint_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_verdict       (o_verdict),
        .o_delay_ms      (o_delay_ms),
        .o_attempt_index (o_attempt_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the verdict for one outcome and advance the backoff state
    function automatic t_result decide_verdict(input t_item it);
        logic [63:0] base;
        logic [63:0] wait_ms;
        logic [63:0] product;
        logic        may_retry;
        logic        status_ok;
        t_result     res;
        may_retry = tries_seen < shadow_cfg.retry_limit;
        case (it.status_code)
            ST_TIMEOUT, ST_TOO_MANY, ST_INTERNAL,
            ST_BAD_GATEWAY, ST_UNAVAILABLE, ST_GW_TIMEOUT: status_ok = 1'b1;
            default: status_ok = 1'b0;
        endcase
        res.attempt_index = tries_seen;
        res.delay_ms      = '0;
        if (it.link_failed) begin
            res.verdict = may_retry ? VERDICT_RETRY : VERDICT_FAIL;
        end else if (status_ok && may_retry) begin
            res.verdict = VERDICT_RETRY;
        end else begin
            res.verdict = VERDICT_DELIVER;
        end
        if (res.verdict == VERDICT_RETRY) begin
            // Attempt zero always starts from the current initial delay
            base = (tries_seen == '0) ? {28'd0, shadow_cfg.initial_delay_ms, 16'd0}
                                      : {16'd0, backoff_product};
            if (!it.link_failed && it.hint_present) begin
                wait_ms = 64'(it.hint_seconds) * 64'(MS_PER_SEC);
            end else begin
                wait_ms = (base + 64'h8000) >> FRAC_W;
            end
            if (wait_ms > 64'(shadow_cfg.delay_cap_ms)) begin
                wait_ms = 64'(shadow_cfg.delay_cap_ms);
            end
            res.delay_ms = wait_ms[DELAY_W-1:0];
            // Grow the product, rounding half-up and saturating at 48 bits
            product = (base * 64'(shadow_cfg.growth_factor_q8) + 64'd128) >> 8;
            backoff_product = (product > 64'hFFFF_FFFF_FFFF) ? '1 : product[BACKOFF_W-1:0];
            tries_seen = tries_seen + 8'd1;
        end else begin
            tries_seen      = '0;
            backoff_product = {12'd0, shadow_cfg.initial_delay_ms, 16'd0};
        end
        return res;
    endfunction

    // Mostly retryable outcomes with random content, the rest anything the fields allow
    function automatic t_item random_outcome(input int retry_pct);
        t_item it;
        it.link_failed  = 1'($urandom_range(1));
        it.status_code  = 10'($urandom_range(1023));
        it.hint_present = 1'($urandom_range(1));
        it.hint_seconds = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(120));
        if ($urandom_range(99) < retry_pct) begin
            it.link_failed = 1'b0;
            case ($urandom_range(6))
                0: it.link_failed = 1'b1;
                1: it.status_code = ST_TIMEOUT;
                2: it.status_code = ST_TOO_MANY;
                3: it.status_code = ST_INTERNAL;
                4: it.status_code = ST_BAD_GATEWAY;
                5: it.status_code = ST_UNAVAILABLE;
                default: it.status_code = ST_GW_TIMEOUT;
            endcase
        end else if ($urandom_range(3) != 0) begin
            it.link_failed = 1'b0;
        end
        return it;
    endfunction

    // Write one register; called on a falling edge, returns on the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RETRY_LIMIT: shadow_cfg.retry_limit      = data[ATTEMPT_W-1:0];
            CFG_INIT_DELAY:  shadow_cfg.initial_delay_ms = data[INIT_W-1:0];
            CFG_GROWTH:      shadow_cfg.growth_factor_q8 = data[GROWTH_W-1:0];
            CFG_DELAY_CAP:   shadow_cfg.delay_cap_ms     = data[DELAY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Send one outcome beat, holding valid across the gap-free case
    task automatic send_outcome(input t_item it, input logic known, input t_result want);
        t_result got;
        while (!steady_phase && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_link_failed  <= it.link_failed;
        i_status_code  <= it.status_code;
        i_hint_present <= it.hint_present;
        i_hint_seconds <= it.hint_seconds;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = decide_verdict(it);
        verdicts_due.push_back(known ? want : got);
        outcomes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every verdict has come back
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
    endtask

    // Stall the verdict side at random, except in the steady phase
    always @(negedge i_clk) begin
        i_out_ready <= steady_phase || ($urandom_range(99) >= 34);
    end

    // Check each verdict beat against the oldest expectation
    always @(posedge i_clk) begin : verdict_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict beat %0d delay %0d attempt %0d",
                         $time, o_verdict, o_delay_ms, o_attempt_index);
                error_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d, got %0d",
                             $time, want.verdict, o_verdict);
                    error_count++;
                end
                if (o_delay_ms !== want.delay_ms) begin
                    $display("%0t: delay_ms expected %0d, got %0d",
                             $time, want.delay_ms, o_delay_ms);
                    error_count++;
                end
                if (o_attempt_index !== want.attempt_index) begin
                    $display("%0t: attempt_index expected %0d, got %0d",
                             $time, want.attempt_index, o_attempt_index);
                    error_count++;
                end
                case (want.verdict)
                    VERDICT_RETRY: retries_seen++;
                    VERDICT_FAIL:  fails_seen++;
                    default:       delivers_seen++;
                endcase
            end
        end
    end

    // Abandon a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int      n_items;
        int      retry_pct;
        t_item   it;
        t_result want;
        shadow_cfg.retry_limit      = RST_RETRY_LIMIT;
        shadow_cfg.initial_delay_ms = RST_INIT_DELAY;
        shadow_cfg.growth_factor_q8 = RST_GROWTH;
        shadow_cfg.delay_cap_ms     = RST_DELAY_CAP;
        tries_seen      = '0;
        backoff_product = {12'd0, RST_INIT_DELAY, 16'd0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            n_items   = 200;
            retry_pct = 85;
            if (ph == 0) begin
                // Walk the directed table under the reset settings
                for (int r = 0; r < NUM_ROWS; r++) begin
                    it.link_failed     = directed_rows[r].link_failed;
                    it.status_code     = directed_rows[r].status_code;
                    it.hint_present    = directed_rows[r].hint_present;
                    it.hint_seconds    = directed_rows[r].hint_seconds;
                    want.verdict       = directed_rows[r].verdict;
                    want.delay_ms      = directed_rows[r].delay_ms;
                    want.attempt_index = directed_rows[r].attempt_index;
                    send_outcome(it, directed_rows[r].known, want);
                end
                n_items   = 250;
                retry_pct = 80;
            end else begin
                drain_verdicts();
                case (ph)
                    1: begin
                        // Zero limit with every other register at its top value
                        write_reg(CFG_RETRY_LIMIT, 32'd0);
                        write_reg(CFG_INIT_DELAY, 32'h000F_FFFF);
                        write_reg(CFG_GROWTH, 32'h0000_FFFF);
                        write_reg(CFG_DELAY_CAP, 32'hFFFF_FFFF);
                        write_reg(CFG_SPARE_IDX, $urandom);
                        write_reg(CFG_TOP_IDX, $urandom);
                        n_items   = 100;
                        retry_pct = 70;
                    end
                    2: begin
                        // Full-length sequence that drives the product into saturation
                        write_reg(CFG_RETRY_LIMIT, 32'd255);
                        n_items   = 300;
                        retry_pct = 100;
                    end
                    3: begin
                        write_reg(CFG_INIT_DELAY, 32'd0);
                        write_reg(CFG_GROWTH, 32'd0);
                        write_reg(CFG_DELAY_CAP, 32'd0);
                        n_items   = 150;
                        retry_pct = 90;
                    end
                    4: begin
                        write_reg(CFG_RETRY_LIMIT, 32'd12);
                        write_reg(CFG_INIT_DELAY, $urandom);
                        write_reg(CFG_GROWTH, $urandom);
                        write_reg(CFG_DELAY_CAP, $urandom);
                        n_items = 300;
                    end
                    5: begin
                        // Upper data bits set; only the register width must land
                        write_reg(CFG_RETRY_LIMIT, 32'hFFFF_FF08);
                        write_reg(CFG_INIT_DELAY, 32'hFFF0_0001);
                        write_reg(CFG_GROWTH, 32'hABCD_0100);
                        write_reg(CFG_DELAY_CAP, 32'h000F_FFFF);
                    end
                    default: begin
                        write_reg(CFG_RETRY_LIMIT, $urandom_range(20));
                        write_reg(CFG_INIT_DELAY, $urandom);
                        write_reg(CFG_GROWTH, $urandom_range(1024));
                        write_reg(CFG_DELAY_CAP, $urandom);
                        n_items = 250;
                    end
                endcase
                i_cfg_valid <= 1'b0;
            end
            steady_phase = (ph == 4);
            want = '0;
            for (int n = 0; n < n_items; n++) begin
                send_outcome(random_outcome(retry_pct), 1'b0, want);
            end
        end

        drain_verdicts();
        steady_phase = 1'b0;
        repeat (5) @(negedge i_clk);
        $display("Checked %0d outcomes over %0d register settings", outcomes_sent, NUM_PHASES);
        $display("Verdicts: %0d retry, %0d deliver, %0d fail",
                 retries_seen, delivers_seen, fails_seen);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- retry_backoff_controller_unit.f -----
sv/rbc_pkg.sv
sv/rbc_decide.sv
sv/retry_backoff_controller_unit.sv
tb/tb_retry_backoff_controller_unit.sv
